### src/lbp_pkg.sv
package lbp_pkg;

	localparam int LevelW  = 7;
	localparam int PeriodW = 8;
	localparam int SlotW   = 7;
	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 8;

	localparam logic [SlotW-1:0]  PeriodTicks = 7'd100;
	localparam logic [LevelW-1:0] LevelTop    = 7'd100;

	localparam logic [CfgIdxW-1:0] RegLevelMin  = 2'd0;
	localparam logic [CfgIdxW-1:0] RegLevelMax  = 2'd1;
	localparam logic [CfgIdxW-1:0] RegPeriodsPl = 2'd2;

	localparam logic [LevelW-1:0] LevelMinRst  = 7'd0;
	localparam logic [LevelW-1:0] LevelMaxRst  = 7'd100;
	localparam logic [PeriodW-1:0] PeriodsPlRst = 8'd10;

	localparam logic [SlotW-1:0] GammaRom [0:100] = '{
		7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd1,   7'd1,   7'd1,
		7'd1,   7'd1,   7'd2,   7'd2,   7'd2,   7'd3,   7'd3,   7'd4,   7'd4,   7'd5,
		7'd5,   7'd6,   7'd7,   7'd8,   7'd9,   7'd10,  7'd11,  7'd12,  7'd13,  7'd14,
		7'd15,  7'd16,  7'd18,  7'd19,  7'd21,  7'd22,  7'd24,  7'd25,  7'd27,  7'd29,
		7'd31,  7'd33,  7'd35,  7'd37,  7'd39,  7'd41,  7'd43,  7'd46,  7'd48,  7'd51,
		7'd53,  7'd56,  7'd59,  7'd61,  7'd64,  7'd67,  7'd70,  7'd73,  7'd76,  7'd79,
		7'd82,  7'd85,  7'd88,  7'd91,  7'd94,  7'd97,  7'd100, 7'd100, 7'd100, 7'd100,
		7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100,
		7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100,
		7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100,
		7'd100
	};

	// saturate levels above the top of the table
	function automatic logic [SlotW-1:0] gamma_lookup(input logic [LevelW-1:0] lvl);
		logic [LevelW-1:0] idx;
		idx = (lvl > LevelTop) ? LevelTop : lvl;
		return GammaRom[idx];
	endfunction

endpackage

### src/led_breathing_pwm.sv
// Channel   Dir  Width  Contents
// s_axis    in   8      tdata[0] advance, [7:1] zero
// m_axis    out  16     tdata[0] led_on, [7:1] level, [8] fading_out, [15:9] zero
// cfg       in   2/8    cfg_we, cfg_index, cfg_wdata (no read-back)
//
// One result per input transfer, registered in the cycle after the transfer; a
// transfer can be taken in every cycle that m_axis does not stall the single output register.
// The output register takes a new result while the current one is being taken.
// Reset clears the counters, starts fade-in at level_min and loads register
// defaults. A stall on m_axis holds s_tready low once the output register is full.
module led_breathing_pwm (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] advance
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [0] led_on, [7:1] level, [8] fading_out
	input  logic        cfg_we,
	input  logic [lbp_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [lbp_pkg::CfgDataW-1:0] cfg_wdata
);

	localparam int LW = lbp_pkg::LevelW;
	localparam int PW = lbp_pkg::PeriodW;
	localparam int SW = lbp_pkg::SlotW;

	logic [LW-1:0] level_min_q, level_max_q;
	logic [PW-1:0] ppl_q;

	logic [SW-1:0] slot_q, slot_n;
	logic [PW-1:0] period_q, period_n;
	logic [LW-1:0] cur_q, cur_n;
	logic          down_q, down_n;
	logic          hold_q, hold_n;

	logic          out_valid_q;
	logic [15:0]   out_data_q;

	logic          s_xfer;
	logic [SW:0]   slot_inc;
	logic [PW:0]   period_inc;
	logic [PW-1:0] ppl_eff;
	logic [LW:0]   cur_inc;
	logic [LW-1:0] shown;
	logic          led;

	assign s_tready = !out_valid_q || m_tready;
	assign s_xfer   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_min_q <= lbp_pkg::LevelMinRst;
			level_max_q <= lbp_pkg::LevelMaxRst;
			ppl_q       <= lbp_pkg::PeriodsPlRst;
		end else if (cfg_we) begin
			case (cfg_index)
				lbp_pkg::RegLevelMin:  level_min_q <= cfg_wdata[LW-1:0];
				lbp_pkg::RegLevelMax:  level_max_q <= cfg_wdata[LW-1:0];
				lbp_pkg::RegPeriodsPl: ppl_q       <= cfg_wdata[PW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		slot_n     = slot_q;
		period_n   = period_q;
		cur_n      = cur_q;
		down_n     = down_q;
		hold_n     = hold_q;
		slot_inc   = {1'b0, slot_q} + 1'b1;
		period_inc = {1'b0, period_q} + 1'b1;
		cur_inc    = {1'b0, cur_q} + 1'b1;
		ppl_eff    = (ppl_q == '0) ? PW'(1) : ppl_q;
		if (s_tdata[0]) begin
			slot_n = slot_inc[SW-1:0];
			if (slot_inc >= {1'b0, lbp_pkg::PeriodTicks}) begin
				slot_n   = '0;
				period_n = period_inc[PW-1:0];
				if (period_inc >= {1'b0, ppl_eff}) begin
					period_n = '0;
					if (hold_q) begin
						// start the opposite phase
						down_n = !down_q;
						if (down_q) begin
							cur_n  = level_min_q;
							hold_n = level_min_q >= level_max_q;
						end else begin
							cur_n  = level_max_q;
							hold_n = level_max_q <= level_min_q;
						end
					end else if (!down_q) begin
						if (cur_inc >= {1'b0, level_max_q})
							hold_n = 1'b1;
						cur_n = cur_inc[LW-1:0];
					end else begin
						if (cur_q == '0 || (cur_q - 1'b1) <= level_min_q) begin
							hold_n = 1'b1;
							if (cur_q != '0)
								cur_n = cur_q - 1'b1;
						end else begin
							cur_n = cur_q - 1'b1;
						end
					end
				end
			end
		end
		shown = hold_n ? (down_n ? level_min_q : level_max_q) : cur_n;
		led   = slot_n < lbp_pkg::gamma_lookup(shown);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q      <= '0;
			period_q    <= '0;
			cur_q       <= lbp_pkg::LevelMinRst;
			down_q      <= 1'b0;
			hold_q      <= lbp_pkg::LevelMinRst >= lbp_pkg::LevelMaxRst;
			out_valid_q <= 1'b0;
		end else begin
			if (s_xfer) begin
				slot_q      <= slot_n;
				period_q    <= period_n;
				cur_q       <= cur_n;
				down_q      <= down_n;
				hold_q      <= hold_n;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_xfer)
			out_data_q <= {7'd0, down_n, shown, led};
	end

endmodule

### src/lbp_checker.sv
module lbp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        cfg_we,
	input logic [lbp_pkg::CfgIdxW-1:0]  cfg_index,
	input logic [lbp_pkg::CfgDataW-1:0] cfg_wdata
);

	// every input transfer leaves a result in the output register
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("no result after input transfer");

	// input side stalls only behind a full, stalled output register
	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("s_tready does not follow output register state");

	// stalled result holds
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// dark levels never light the LED
	a_dark: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[7:1] < 7'd7 |-> !m_tdata[0])
		else $error("LED on at a dark level");

	// saturated levels keep the LED on for the whole period
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[7:1] >= 7'd66 |-> m_tdata[0])
		else $error("LED off at a saturated level");

endmodule

bind led_breathing_pwm lbp_checker u_lbp_checker (.*);

### tb/sv/tb_led_breathing_pwm.sv
module tb_led_breathing_pwm;

	localparam int WatchdogLimit = 2000;

	localparam byte unsigned DutyOfLevel [0:100] = '{
		0,   0,   0,   0,   0,   0,   0,   1,   1,   1,
		1,   1,   2,   2,   2,   3,   3,   4,   4,   5,
		5,   6,   7,   8,   9,   10,  11,  12,  13,  14,
		15,  16,  18,  19,  21,  22,  24,  25,  27,  29,
		31,  33,  35,  37,  39,  41,  43,  46,  48,  51,
		53,  56,  59,  61,  64,  67,  70,  73,  76,  79,
		82,  85,  88,  91,  94,  97,  100, 100, 100, 100,
		100, 100, 100, 100, 100, 100, 100, 100, 100, 100,
		100, 100, 100, 100, 100, 100, 100, 100, 100, 100,
		100, 100, 100, 100, 100, 100, 100, 100, 100, 100,
		100
	};

	// holds in the reset state, then ticks mixed with holds
	localparam logic [21:0] DirectedTicks = 22'b1110_1101_1111_0101_1011_00;

	typedef struct packed {
		logic                       fading_out;
		logic [lbp_pkg::LevelW-1:0] level;
		logic                       led_on;
	} glow_t;

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [7:0]                   s_tdata = 8'd0;   // [0] advance
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	logic [15:0]                  m_tdata;   // [0] led_on, [7:1] level, [8] fading_out
	logic                         cfg_we;
	logic [lbp_pkg::CfgIdxW-1:0]  cfg_index;
	logic [lbp_pkg::CfgDataW-1:0] cfg_wdata;

	// breathing state as the block should hold it
	logic [lbp_pkg::LevelW-1:0]  lvl_lo;
	logic [lbp_pkg::LevelW-1:0]  lvl_hi;
	logic [lbp_pkg::PeriodW-1:0] ppl_cfg;
	int                          slot_n;
	int                          period_n;
	logic [lbp_pkg::LevelW-1:0]  cur_lvl;
	logic                        going_down;
	logic                        holding;

	bit   tick_q [$];
	glow_t glow_q [$];
	int   outstanding = 0;
	int   errors = 0;
	int   idle_cycles = 0;
	bit   s_took = 1'b0;
	int   s_gap = 0;
	int   m_gap = 0;
	bit   s_calm = 1'b0;
	bit   m_calm = 1'b0;

	led_breathing_pwm uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #10 clk = ~clk;

	task automatic flag_error(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		errors++;
	endtask

	function automatic void start_phase(input logic down);
		going_down = down;
		cur_lvl = down ? lvl_hi : lvl_lo;
		holding = down ? (cur_lvl <= lvl_lo) : (cur_lvl >= lvl_hi);
	endfunction

	function automatic void step_level();
		int nxt;
		if (holding) begin
			start_phase(!going_down);
		end else if (!going_down) begin
			nxt = int'(cur_lvl) + 1;
			if (nxt >= int'(lvl_hi))
				holding = 1'b1;
			cur_lvl = nxt[lbp_pkg::LevelW-1:0];
		end else if (cur_lvl == 0 || int'(cur_lvl) - 1 <= int'(lvl_lo)) begin
			holding = 1'b1;
			if (cur_lvl != 0)
				cur_lvl = cur_lvl - 1'b1;
		end else begin
			cur_lvl = cur_lvl - 1'b1;
		end
	endfunction

	function automatic glow_t breathe_tick(input logic adv);
		logic [lbp_pkg::LevelW-1:0] shown;
		int                         ppl;
		int                         duty;
		glow_t                      r;
		if (adv) begin
			slot_n++;
			if (slot_n >= 100) begin
				// zero periods per level behaves as one
				ppl = (ppl_cfg != 0) ? int'(ppl_cfg) : 1;
				slot_n = 0;
				period_n++;
				if (period_n >= ppl) begin
					period_n = 0;
					step_level();
				end
			end
		end
		shown = holding ? (going_down ? lvl_lo : lvl_hi) : cur_lvl;
		duty = DutyOfLevel[(shown > 7'd100) ? 100 : int'(shown)];
		r.led_on = (slot_n < duty);
		r.level = shown;
		r.fading_out = going_down;
		return r;
	endfunction

	function automatic int pick_gap(input bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// sender: hold the item until its transfer, then maybe idle
	always @(negedge clk) begin
		if (!s_tvalid || s_took) begin
			s_took = 1'b0;
			if (s_gap > 0) begin
				s_gap--;
				s_tvalid <= 1'b0;
			end else if (tick_q.size() != 0) begin
				s_tdata <= {7'd0, tick_q.pop_front()};
				s_tvalid <= 1'b1;
				if ($urandom_range(0, 199) == 0)
					s_calm = !s_calm;
				s_gap = pick_gap(s_calm);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		if ($urandom_range(0, 299) == 0)
			m_calm = !m_calm;
		if (m_gap == 0 && !m_calm && $urandom_range(0, 4) == 0)
			m_gap = pick_gap(1'b0);
		if (m_gap > 0) begin
			m_gap--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		glow_t want;
		bit    moved;
		moved = 1'b0;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					lbp_pkg::RegLevelMin:  lvl_lo = cfg_wdata[lbp_pkg::LevelW-1:0];
					lbp_pkg::RegLevelMax:  lvl_hi = cfg_wdata[lbp_pkg::LevelW-1:0];
					lbp_pkg::RegPeriodsPl: ppl_cfg = cfg_wdata;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				glow_q.push_back(breathe_tick(s_tdata[0]));
				s_took = 1'b1;
				moved = 1'b1;
			end
			if (m_tvalid && m_tready) begin
				moved = 1'b1;
				if (glow_q.size() == 0) begin
					flag_error($sformatf("result 0x%h with nothing expected", m_tdata));
				end else begin
					want = glow_q.pop_front();
					outstanding--;
					if (m_tdata[0] !== want.led_on)
						flag_error($sformatf("led_on got %b expected %b",
							m_tdata[0], want.led_on));
					if (m_tdata[7:1] !== want.level)
						flag_error($sformatf("level got %0d expected %0d",
							m_tdata[7:1], want.level));
					if (m_tdata[8] !== want.fading_out)
						flag_error($sformatf("fading_out got %b expected %b",
							m_tdata[8], want.fading_out));
				end
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= WatchdogLimit) begin
				$display("led_breathing_pwm verification failed");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [lbp_pkg::CfgIdxW-1:0] idx,
			input logic [lbp_pkg::CfgDataW-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_tick(input bit adv);
		tick_q.push_back(adv);
		outstanding++;
	endtask

	// wait out every result, then let the output register settle
	task automatic drain();
		wait (outstanding == 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic run_phase(input int n_items, input int hold_pct);
		for (int n = 0; n < n_items; n++)
			queue_tick($urandom_range(0, 99) >= hold_pct);
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = lbp_pkg::RegLevelMin;
		cfg_wdata = 8'd0;
		lvl_lo = 7'd0;
		lvl_hi = 7'd100;
		ppl_cfg = 8'd10;
		slot_n = 0;
		period_n = 0;
		start_phase(1'b0);
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < 22; i++)
			queue_tick(DirectedTicks[i]);
		drain();

		// min above max and above the table, bit 7 of the write dropped
		write_reg(lbp_pkg::RegLevelMin, 8'hFF);
		write_reg(lbp_pkg::RegLevelMax, 8'd0);
		write_reg(lbp_pkg::RegPeriodsPl, 8'd0);
		run_phase(300, 10);

		write_reg(lbp_pkg::RegLevelMin, 8'd40);
		write_reg(lbp_pkg::RegLevelMax, 8'd44);
		write_reg(lbp_pkg::RegPeriodsPl, 8'd1);
		run_phase(650, 8);

		write_reg(lbp_pkg::RegLevelMin, 8'd100);
		write_reg(lbp_pkg::RegLevelMax, 8'd100);
		write_reg(lbp_pkg::RegPeriodsPl, 8'd255);
		run_phase(120, 35);

		// collapse into a hold so the next ramp starts from its bounds
		write_reg(lbp_pkg::RegLevelMin, 8'd127);
		write_reg(lbp_pkg::RegLevelMax, 8'd0);
		write_reg(lbp_pkg::RegPeriodsPl, 8'd1);
		run_phase(200, 5);

		write_reg(lbp_pkg::RegLevelMin, 8'd124);
		write_reg(lbp_pkg::RegLevelMax, 8'd127);
		write_reg(lbp_pkg::RegPeriodsPl, 8'd1);
		run_phase(200, 10);

		if (glow_q.size() != 0)
			flag_error($sformatf("%0d results never arrived", glow_q.size()));
		if (errors == 0)
			$display("led_breathing_pwm verification clean");
		else
			$display("led_breathing_pwm verification failed");
		$finish;
	end

endmodule

### filelist.f
src/lbp_pkg.sv
src/led_breathing_pwm.sv
src/lbp_checker.sv
tb/sv/tb_led_breathing_pwm.sv
